// ===== rtl/tlw_pkg.sv =====
// Shared types and constants for the text run layout block.
// Used by tlw_ctrl, tlw_dp and text_run_layout_wrap; no dependencies.
package tlw_pkg;

  // Parameter defaults
  localparam int COORD_BITS_DEF = 12;
  localparam int INDEX_BITS_DEF = 16;

  // Fixed field widths
  localparam int CODE_BITS      = 8;
  localparam int CWIDTH_BITS    = 6;
  localparam int LINE_H_BITS    = 8;
  localparam int OUT_IDX_BITS   = 16;
  localparam int CFG_ADDR_BITS  = 3;

  // Register reset values
  localparam int LEFT_X_RST   = 0;
  localparam int RIGHT_X_RST  = 800;
  localparam int BOTTOM_Y_RST = 1024;
  localparam int LINE_H_RST   = 16;
  localparam int TAB_STEP_RST = 72;

  // Character codes
  localparam logic [CODE_BITS-1:0] CODE_TAB   = 8'd9;
  localparam logic [CODE_BITS-1:0] CODE_NL    = 8'd10;
  localparam logic [CODE_BITS-1:0] CODE_SPACE = 8'd32;
  localparam logic [CODE_BITS-1:0] CODE_DEL   = 8'd127;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_LEFT_X   = 3'd0,
    REG_RIGHT_X  = 3'd1,
    REG_BOTTOM_Y = 3'd2,
    REG_LINE_H   = 3'd3,
    REG_TAB_STEP = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_DISP,
    S_NL,
    S_BRK,
    S_TAB_FLUSH,
    S_DIV_GO,
    S_DIV_WAIT,
    S_TAB_CHECK,
    S_TAB_RETRY,
    S_TAB_EMIT,
    S_CHAR,
    S_CHAR2,
    S_LAST,
    S_FLUSH
  } state_t;

  // Where a line break returns to
  typedef enum logic [1:0] {
    RET_NL,
    RET_TAB,
    RET_CHAR
  } ret_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_NL_CNT,
    OP_BRK,
    OP_TAB_FLUSH,
    OP_DIV_START,
    OP_TAB_SET,
    OP_TAB_RETRY,
    OP_TAB_EMIT,
    OP_CHAR,
    OP_FINAL,
    OP_STOP,
    OP_PUSH_LAST
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic stopped;
    logic is_nl;
    logic is_tab;
    logic is_last;
    logic wrap_char;
    logic tab_wrap;
    logic flush_need;
    logic final_ok;
    logic brk_stop;
    logic emit_ok;
    logic pend_v;
    logic out_free;
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/tlw_div.sv =====
// Iterative restoring divider for the tab stop: one quotient bit per cycle, remainder out.
// Depends on nothing but its parameter.
module tlw_div #(
  parameter int W = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dvd,
  input  logic [W-1:0] dvs,
  output logic [W-1:0] rem,
  output logic         done
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  assign shifted = {rem_r, dvd_r[W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dvd;
      dvs_nxt  = dvs;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      // keep the trial difference when it does not go negative
      rem_nxt = trial[W] ? shifted[W-1:0] : trial[W-1:0];
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

// ===== rtl/tlw_ctrl.sv =====
// Sequencer for the text run layout block: walks each character through its steps.
// Depends on tlw_pkg (state_t, ret_t, cmd_t, stat_t).
module tlw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tlw_pkg::stat_t stat,
  output tlw_pkg::cmd_t  cmd
);

  tlw_pkg::state_t state_r, state_nxt;
  tlw_pkg::ret_t   ret_r, ret_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      tlw_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = tlw_pkg::S_INIT;
      end
      tlw_pkg::S_INIT: state_nxt = tlw_pkg::S_DISP;
      tlw_pkg::S_DISP: begin
        if (stat.stopped)     state_nxt = tlw_pkg::S_IDLE;
        else if (stat.is_nl)  state_nxt = tlw_pkg::S_NL;
        else if (stat.is_tab) state_nxt = tlw_pkg::S_TAB_FLUSH;
        else                  state_nxt = tlw_pkg::S_CHAR;
      end
      tlw_pkg::S_NL: begin
        ret_nxt   = tlw_pkg::RET_NL;
        state_nxt = tlw_pkg::S_BRK;
      end
      tlw_pkg::S_BRK: begin
        if (stat.emit_ok) begin
          if (stat.brk_stop) begin
            state_nxt = tlw_pkg::S_FLUSH;
          end else begin
            unique case (ret_r)
              tlw_pkg::RET_NL:   state_nxt = tlw_pkg::S_LAST;
              tlw_pkg::RET_TAB:  state_nxt = tlw_pkg::S_TAB_RETRY;
              tlw_pkg::RET_CHAR: state_nxt = tlw_pkg::S_CHAR2;
              default:           state_nxt = tlw_pkg::S_LAST;
            endcase
          end
        end
      end
      tlw_pkg::S_TAB_FLUSH: begin
        if (!stat.flush_need || stat.emit_ok) state_nxt = tlw_pkg::S_DIV_GO;
      end
      tlw_pkg::S_DIV_GO:   state_nxt = tlw_pkg::S_DIV_WAIT;
      tlw_pkg::S_DIV_WAIT: begin
        if (stat.div_done) state_nxt = tlw_pkg::S_TAB_CHECK;
      end
      tlw_pkg::S_TAB_CHECK: begin
        if (stat.tab_wrap) begin
          ret_nxt   = tlw_pkg::RET_TAB;
          state_nxt = tlw_pkg::S_BRK;
        end else begin
          state_nxt = tlw_pkg::S_TAB_EMIT;
        end
      end
      tlw_pkg::S_TAB_RETRY: state_nxt = tlw_pkg::S_TAB_EMIT;
      tlw_pkg::S_TAB_EMIT: begin
        if (stat.emit_ok) state_nxt = tlw_pkg::S_LAST;
      end
      tlw_pkg::S_CHAR: begin
        if (stat.wrap_char) begin
          ret_nxt   = tlw_pkg::RET_CHAR;
          state_nxt = tlw_pkg::S_BRK;
        end else begin
          state_nxt = tlw_pkg::S_CHAR2;
        end
      end
      tlw_pkg::S_CHAR2: state_nxt = tlw_pkg::S_LAST;
      tlw_pkg::S_LAST: begin
        if (!stat.is_last || !stat.final_ok || stat.emit_ok) state_nxt = tlw_pkg::S_FLUSH;
      end
      tlw_pkg::S_FLUSH: begin
        if (!stat.pend_v || stat.out_free) state_nxt = tlw_pkg::S_IDLE;
      end
      default: state_nxt = tlw_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op    = tlw_pkg::OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      tlw_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = tlw_pkg::OP_LOAD;
      end
      tlw_pkg::S_INIT: cmd.op = tlw_pkg::OP_INIT;
      tlw_pkg::S_DISP: cmd.op = tlw_pkg::OP_NONE;
      tlw_pkg::S_NL:   cmd.op = tlw_pkg::OP_NL_CNT;
      tlw_pkg::S_BRK: begin
        if (stat.emit_ok) cmd.op = tlw_pkg::OP_BRK;
      end
      tlw_pkg::S_TAB_FLUSH: begin
        if (stat.flush_need && stat.emit_ok) cmd.op = tlw_pkg::OP_TAB_FLUSH;
      end
      tlw_pkg::S_DIV_GO: cmd.op = tlw_pkg::OP_DIV_START;
      tlw_pkg::S_DIV_WAIT: begin
        if (stat.div_done) cmd.op = tlw_pkg::OP_TAB_SET;
      end
      tlw_pkg::S_TAB_CHECK: cmd.op = tlw_pkg::OP_NONE;
      tlw_pkg::S_TAB_RETRY: cmd.op = tlw_pkg::OP_TAB_RETRY;
      tlw_pkg::S_TAB_EMIT: begin
        if (stat.emit_ok) cmd.op = tlw_pkg::OP_TAB_EMIT;
      end
      tlw_pkg::S_CHAR:  cmd.op = tlw_pkg::OP_NONE;
      tlw_pkg::S_CHAR2: cmd.op = tlw_pkg::OP_CHAR;
      tlw_pkg::S_LAST: begin
        if (stat.is_last) begin
          if (!stat.final_ok)    cmd.op = tlw_pkg::OP_STOP;
          else if (stat.emit_ok) cmd.op = tlw_pkg::OP_FINAL;
        end
      end
      tlw_pkg::S_FLUSH: begin
        if (stat.pend_v && stat.out_free) cmd.op = tlw_pkg::OP_PUSH_LAST;
      end
      default: cmd.op = tlw_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlw_pkg::S_IDLE;
      ret_r   <= tlw_pkg::RET_NL;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule

// ===== rtl/tlw_dp.sv =====
// Datapath of the text run layout block: frame registers, pen and run state,
// one staged word plus the output register. Depends on tlw_pkg and tlw_div.
module tlw_dp #(
  parameter int COORD_BITS = tlw_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = tlw_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [tlw_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [COORD_BITS-1:0]               cfg_data,
  // input word fields
  input  logic [tlw_pkg::CODE_BITS-1:0]       char_code,
  input  logic [tlw_pkg::CWIDTH_BITS-1:0]     char_width,
  input  logic                                first_of_string,
  input  logic [COORD_BITS-1:0]               start_x,
  input  logic [COORD_BITS-1:0]               start_y,
  input  logic                                last_of_string,
  // sequencer
  input  tlw_pkg::cmd_t                       cmd,
  output tlw_pkg::stat_t                      stat,
  // output word
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [COORD_BITS-1:0]               run_x0,
  output logic [COORD_BITS-1:0]               run_y,
  output logic [COORD_BITS-1:0]               run_x1,
  output logic [tlw_pkg::OUT_IDX_BITS-1:0]    run_index,
  output logic [tlw_pkg::OUT_IDX_BITS-1:0]    run_count,
  output logic                                string_complete,
  output logic                                last_result
);

  localparam int C  = COORD_BITS;
  localparam int I  = INDEX_BITS;
  localparam int OI = tlw_pkg::OUT_IDX_BITS;

  // frame registers
  logic [C-1:0] left_r, right_r, bottom_r, tab_r;
  logic [tlw_pkg::LINE_H_BITS-1:0] lh_r;

  // latched input word
  logic [tlw_pkg::CODE_BITS-1:0]   code_r;
  logic [tlw_pkg::CWIDTH_BITS-1:0] cw_r;
  logic                            first_r, last_r;
  logic [C-1:0]                    sx_r, sy_r;

  // layout state
  logic [C-1:0] pen_r, pen_nxt;
  logic [C-1:0] ly_r, ly_nxt;
  logic [C-1:0] rbx_r, rbx_nxt;
  logic [I-1:0] rbi_r, rbi_nxt;
  logic [I-1:0] rlen_r, rlen_nxt;
  logic [I-1:0] cidx_r, cidx_nxt;
  logic         stopped_r, stopped_nxt;
  logic [C:0]   v_r, v_nxt;

  // staged word and output register
  logic         pend_v_r, pend_v_nxt;
  logic [C-1:0] pd_x0_r, pd_y_r, pd_x1_r;
  logic [OI-1:0] pd_idx_r, pd_cnt_r;
  logic         pd_comp_r;
  logic         out_v_r, out_v_nxt;
  logic [C-1:0] o_x0_r, o_y_r, o_x1_r;
  logic [OI-1:0] o_idx_r, o_cnt_r;
  logic         o_comp_r, o_last_r;

  // emit bus
  logic         do_emit, out_load, push_last, div_start;
  logic [C-1:0] e_x0, e_y, e_x1;
  logic [I-1:0] e_idx, e_cnt;
  logic         e_comp;
  logic [I+OI-1:0] e_idx_ext, e_cnt_ext;

  // arithmetic
  logic [C-1:0] step;
  logic         pen_ge;
  logic [C-1:0] dvd;
  logic [C-1:0] rem;
  logic         div_done;
  logic [C:0]   pen_w, ny;
  logic [C-1:0] pen_w_sat, v_sat;
  logic         printable;
  logic         out_free;

  assign step      = (tab_r == '0) ? C'(1) : tab_r;
  assign pen_ge    = pen_r >= left_r;
  assign dvd       = pen_ge ? (pen_r - left_r) : (left_r - pen_r);
  assign pen_w     = {1'b0, pen_r} + (C+1)'(cw_r);
  assign pen_w_sat = pen_w[C] ? '1 : pen_w[C-1:0];
  assign v_sat     = v_r[C] ? '1 : v_r[C-1:0];
  assign ny        = {1'b0, ly_r} + (C+1)'(lh_r);
  assign printable = (code_r >= tlw_pkg::CODE_SPACE) && (code_r <= tlw_pkg::CODE_DEL);
  assign out_free  = !out_v_r || out_tready;

  tlw_div #(.W(C)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (dvd),
    .dvs   (step),
    .rem   (rem),
    .done  (div_done)
  );

  always_comb begin
    stat.stopped    = stopped_r;
    stat.is_nl      = code_r == tlw_pkg::CODE_NL;
    stat.is_tab     = code_r == tlw_pkg::CODE_TAB;
    stat.is_last    = last_r;
    stat.wrap_char  = printable && (pen_w > {1'b0, right_r});
    stat.tab_wrap   = v_r > {1'b0, right_r};
    stat.flush_need = rlen_r != '0;
    stat.final_ok   = ly_r < bottom_r;
    stat.brk_stop   = ny[C] || (ny >= {1'b0, bottom_r});
    stat.emit_ok    = !pend_v_r || out_free;
    stat.pend_v     = pend_v_r;
    stat.out_free   = out_free;
    stat.div_done   = div_done;
  end

  always_comb begin
    pen_nxt     = pen_r;
    ly_nxt      = ly_r;
    rbx_nxt     = rbx_r;
    rbi_nxt     = rbi_r;
    rlen_nxt    = rlen_r;
    cidx_nxt    = cidx_r;
    stopped_nxt = stopped_r;
    v_nxt       = v_r;
    do_emit     = 1'b0;
    push_last   = 1'b0;
    div_start   = 1'b0;
    e_x0        = rbx_r;
    e_y         = ly_r;
    e_x1        = pen_r;
    e_idx       = rbi_r;
    e_cnt       = rlen_r;
    e_comp      = 1'b0;
    unique case (cmd.op)
      tlw_pkg::OP_INIT: begin
        if (first_r) begin
          pen_nxt     = sx_r;
          ly_nxt      = sy_r;
          rbx_nxt     = sx_r;
          rbi_nxt     = '0;
          rlen_nxt    = '0;
          cidx_nxt    = '0;
          stopped_nxt = 1'b0;
        end
      end
      tlw_pkg::OP_NL_CNT: begin
        rlen_nxt = rlen_r + I'(1);
        cidx_nxt = cidx_r + I'(1);
      end
      tlw_pkg::OP_BRK: begin
        // close the run at the right edge, then drop to the next line or stop at bottom_y
        do_emit = 1'b1;
        e_x1    = right_r;
        rbx_nxt = left_r;
        if (stat.brk_stop) begin
          stopped_nxt = 1'b1;
        end else begin
          ly_nxt   = ny[C-1:0];
          pen_nxt  = left_r;
          rbi_nxt  = cidx_r;
          rlen_nxt = '0;
        end
      end
      tlw_pkg::OP_TAB_FLUSH: begin
        do_emit  = 1'b1;
        rbx_nxt  = pen_r;
        rbi_nxt  = cidx_r;
        rlen_nxt = '0;
      end
      tlw_pkg::OP_DIV_START: div_start = 1'b1;
      tlw_pkg::OP_TAB_SET: begin
        // next stop from the remainder of |pen - left| by the step
        if (pen_ge) v_nxt = {1'b0, pen_r} - {1'b0, rem} + {1'b0, step};
        else        v_nxt = {1'b0, pen_r} + {1'b0, rem} + {1'b0, step};
      end
      tlw_pkg::OP_TAB_RETRY: v_nxt = {1'b0, left_r} + {1'b0, step};
      tlw_pkg::OP_TAB_EMIT: begin
        do_emit  = 1'b1;
        e_x1     = v_sat;
        e_idx    = cidx_r;
        e_cnt    = I'(1);
        pen_nxt  = v_sat;
        rbx_nxt  = v_sat;
        cidx_nxt = cidx_r + I'(1);
        rbi_nxt  = cidx_r + I'(1);
        rlen_nxt = '0;
      end
      tlw_pkg::OP_CHAR: begin
        if (printable) pen_nxt = pen_w_sat;
        rlen_nxt = rlen_r + I'(1);
        cidx_nxt = cidx_r + I'(1);
      end
      tlw_pkg::OP_FINAL: begin
        do_emit     = 1'b1;
        e_comp      = 1'b1;
        stopped_nxt = 1'b1;
      end
      tlw_pkg::OP_STOP:      stopped_nxt = 1'b1;
      tlw_pkg::OP_PUSH_LAST: push_last   = 1'b1;
      default: ;
    endcase
  end

  assign e_idx_ext = {{OI{1'b0}}, e_idx};
  assign e_cnt_ext = {{OI{1'b0}}, e_cnt};

  // a new word pushes the staged one out; the item's end pushes it with last set
  always_comb begin
    out_load   = 1'b0;
    pend_v_nxt = pend_v_r;
    if (do_emit) begin
      out_load   = pend_v_r;
      pend_v_nxt = 1'b1;
    end else if (push_last) begin
      out_load   = 1'b1;
      pend_v_nxt = 1'b0;
    end
    if (out_load)        out_v_nxt = 1'b1;
    else if (out_tready) out_v_nxt = 1'b0;
    else                 out_v_nxt = out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= C'(tlw_pkg::LEFT_X_RST);
      right_r   <= C'(tlw_pkg::RIGHT_X_RST);
      bottom_r  <= C'(tlw_pkg::BOTTOM_Y_RST);
      lh_r      <= tlw_pkg::LINE_H_BITS'(tlw_pkg::LINE_H_RST);
      tab_r     <= C'(tlw_pkg::TAB_STEP_RST);
      pen_r     <= '0;
      ly_r      <= '0;
      rbx_r     <= '0;
      rbi_r     <= '0;
      rlen_r    <= '0;
      cidx_r    <= '0;
      stopped_r <= 1'b1;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          tlw_pkg::REG_LEFT_X:   left_r   <= cfg_data;
          tlw_pkg::REG_RIGHT_X:  right_r  <= cfg_data;
          tlw_pkg::REG_BOTTOM_Y: bottom_r <= cfg_data;
          tlw_pkg::REG_LINE_H:   lh_r     <= cfg_data[tlw_pkg::LINE_H_BITS-1:0];
          tlw_pkg::REG_TAB_STEP: tab_r    <= cfg_data;
          default: ;
        endcase
      end
      pen_r     <= pen_nxt;
      ly_r      <= ly_nxt;
      rbx_r     <= rbx_nxt;
      rbi_r     <= rbi_nxt;
      rlen_r    <= rlen_nxt;
      cidx_r    <= cidx_nxt;
      stopped_r <= stopped_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    if (cmd.op == tlw_pkg::OP_LOAD) begin
      code_r  <= char_code;
      cw_r    <= char_width;
      first_r <= first_of_string;
      sx_r    <= start_x;
      sy_r    <= start_y;
      last_r  <= last_of_string;
    end
    if (out_load) begin
      o_x0_r   <= pd_x0_r;
      o_y_r    <= pd_y_r;
      o_x1_r   <= pd_x1_r;
      o_idx_r  <= pd_idx_r;
      o_cnt_r  <= pd_cnt_r;
      o_comp_r <= pd_comp_r;
      o_last_r <= push_last;
    end
    if (do_emit) begin
      pd_x0_r   <= e_x0;
      pd_y_r    <= e_y;
      pd_x1_r   <= e_x1;
      pd_idx_r  <= e_idx_ext[OI-1:0];
      pd_cnt_r  <= e_cnt_ext[OI-1:0];
      pd_comp_r <= e_comp;
    end
  end

  assign out_tvalid      = out_v_r;
  assign run_x0          = o_x0_r;
  assign run_y           = o_y_r;
  assign run_x1          = o_x1_r;
  assign run_index       = o_idx_r;
  assign run_count       = o_cnt_r;
  assign string_complete = o_comp_r;
  assign last_result     = o_last_r;

endmodule

// ===== rtl/text_run_layout_wrap.sv =====
// Top level of the text run layout block: stream ports, sequencer and datapath.
// Depends on tlw_pkg, tlw_ctrl and tlw_dp (which holds tlw_div).
//
// Lays out a string one character word at a time inside a frame and emits
// runs (start x, line y, end x, first index, length). A newline or a printable
// character that passes right_x closes the run at right_x and wraps to left_x
// on the next line; a tab flushes the pending run, then moves to the next tab
// stop as a one-character run of its own. Once the next line would reach
// bottom_y the rest of the string is ignored until a word with the first flag
// (tuser) starts a new one. The last character (tlast) ends with a final run
// flagged complete if the line is still on screen. Each input word yields zero
// to four output words; out_tlast marks the last of them. One character is
// handled at a time; a tab waits on the tab-stop remainder unit, which resolves
// one bit per cycle. A waiting output word stalls the sequencer only when a
// further word is ready to go. Registers (cfg_addr): 0 left_x, 1 right_x,
// 2 bottom_y, 3 line_height, 4 tab_step (0 acts as 1); other addresses are
// ignored. cfg_ready is always high; write only while the block is idle.
module text_run_layout_wrap #(
  parameter int COORD_BITS = tlw_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = tlw_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // char_code[7:0], char_width[13:8], start_x, start_y, zero pad
  input  logic [((14 + 2*COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // first_of_string
  input  logic                              in_tuser,
  // last_of_string
  input  logic                              in_tlast,
  // output stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // run_x0, run_y, run_x1, run_index[15:0], run_count[15:0], zero pad
  output logic [((3*COORD_BITS + 32 + 7) / 8) * 8 - 1:0] out_tdata,
  // string_complete
  output logic                              out_tuser,
  // last_result
  output logic                              out_tlast,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlw_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [COORD_BITS-1:0]             cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int OUT_W = ((3*C + 32 + 7) / 8) * 8;
  localparam int CB    = tlw_pkg::CODE_BITS;
  localparam int WB    = tlw_pkg::CWIDTH_BITS;
  localparam int OI    = tlw_pkg::OUT_IDX_BITS;

  tlw_pkg::cmd_t  cmd;
  tlw_pkg::stat_t stat;

  logic [C-1:0]  run_x0, run_y, run_x1;
  logic [OI-1:0] run_index, run_count;

  assign cfg_ready = 1'b1;

  tlw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlw_dp #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .char_code       (in_tdata[CB-1:0]),
    .char_width      (in_tdata[CB+WB-1:CB]),
    .first_of_string (in_tuser),
    .start_x         (in_tdata[CB+WB+C-1:CB+WB]),
    .start_y         (in_tdata[CB+WB+2*C-1:CB+WB+C]),
    .last_of_string  (in_tlast),
    .cmd             (cmd),
    .stat            (stat),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .run_x0          (run_x0),
    .run_y           (run_y),
    .run_x1          (run_x1),
    .run_index       (run_index),
    .run_count       (run_count),
    .string_complete (out_tuser),
    .last_result     (out_tlast)
  );

  // pack the run fields from the lowest bit up, zero pad to whole bytes
  assign out_tdata = OUT_W'({run_count, run_index, run_x1, run_y, run_x0});

endmodule
